>>> design/pscu_pkg.sv
// pscu_pkg: shared widths, limits, register indexes and constant tables for the
// pressure/temperature compensation datapath. No dependencies.
`default_nettype none

package pscu_pkg;

  localparam int RAW_W      = 24;
  localparam int IN_DATA_W  = 2 * RAW_W;
  localparam int TEMP_W     = 16;
  localparam int PRS_W      = 23;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SCL_W      = 31;   // scaled raw reading, Q24
  localparam int RECIP_W    = 31;
  localparam int STAGES     = 13;
  localparam int TDLY       = 7;    // temperature result waits for the pressure path

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFFS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_C00         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_C10         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_C01         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_C11         = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_C20_C30     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_C21         = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_OSR         = 3'd7;

  // round(2^48 / k) for scale factors 524288, 1572864, 3670016, 7864320,
  // 253952, 516096, 1040384, 2088960
  localparam logic [RECIP_W-1:0] RECIP_Q48 [8] = '{
    31'd536870912, 31'd178956971, 31'd76695845,  31'd35791394,
    31'd1108378657, 31'd545392673, 31'd270549121, 31'd134744072
  };

  // exact x / 100 for any 32-bit x: (x * ceil(2^37 / 100)) >> 37
  localparam logic [30:0] DIV100_MAGIC = 31'd1374389535;
  localparam int          DIV100_SHIFT = 37;

  // half of 100 * 2^16, rounding offset for the hPa conversion
  localparam int HPA_HALF = 3276800;

  localparam logic signed [TEMP_W-1:0] TEMP_MAX = 16'sh7fff;
  localparam logic signed [TEMP_W-1:0] TEMP_MIN = 16'sh8000;
  localparam logic signed [PRS_W-1:0]  PRS_MAX  = 23'sh3f_ffff;
  localparam logic signed [PRS_W-1:0]  PRS_MIN  = 23'sh40_0000;
  localparam logic [PRS_W-1:0]         PRS_POS_LIM = 23'd4194303;
  localparam logic [PRS_W-1:0]         PRS_NEG_LIM = 23'd4194304;

  typedef struct packed {
    logic                     sat;
    logic signed [PRS_W-1:0]  prs;
    logic signed [TEMP_W-1:0] tmp;
  } res_t;

endpackage

`default_nettype wire

>>> design/pressure_sensor_compensation_unit.sv
// pressure_sensor_compensation_unit: fixed-point temperature and pressure compensation.
// Uses pscu_pkg. One reading per cycle sustained while the result side is not stalled,
// through the 13-stage multiplier pipeline (the a*p, d*p, b*p and e*t products are split
// at bit 24 into partial products) feeding a two-entry output buffer.
// rst_n (synchronous, active low) clears all valid bits and the coefficient registers.
`default_nettype none

module pressure_sensor_compensation_unit (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  // [23:0] raw_temperature, [47:24] raw_pressure
  input  wire logic [pscu_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // [15:0] temperature, [38:16] pressure, [39] zero
  output logic [pscu_pkg::OUT_DATA_W-1:0]        out_tdata,
  // [0] saturated
  output logic [0:0]                             out_tuser,
  input  wire logic                              cfg_wr_en,
  input  wire logic [pscu_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pscu_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int SW = pscu_pkg::SCL_W;

  // coefficient registers
  logic [23:0]        temp_coeffs_r;
  logic signed [19:0] c00_r, c10_r;
  logic signed [15:0] c01_r, c11_r, c21_r;
  logic [31:0]        c2030_r;
  logic [5:0]         osr_r;

  logic signed [11:0] c1, c0h;
  logic signed [15:0] c20, c30;

  assign c1  = $signed(temp_coeffs_r[23:12]);
  assign c0h = $signed(temp_coeffs_r[11:0]);
  assign c20 = $signed(c2030_r[15:0]);
  assign c30 = $signed(c2030_r[31:16]);

  // pipeline control
  logic                        en;
  logic [pscu_pkg::STAGES-1:0] v_r;
  logic                        out_v_r, sk_v_r;
  pscu_pkg::res_t              out_r, sk_r, res;
  logic                        out_free, arrive;

  assign en        = !sk_v_r;
  assign in_tready = en;
  assign out_free  = !out_v_r || out_tready;
  assign arrive    = v_r[pscu_pkg::STAGES-1] && en;

  // stage 1: reading times reciprocal
  logic signed [pscu_pkg::RAW_W-1:0] raw_t, raw_p;
  logic signed [55:0] prod_t1_r, prod_p1_r, prod_t1_nxt, prod_p1_nxt;

  assign raw_t = $signed(in_tdata[pscu_pkg::RAW_W-1:0]);
  assign raw_p = $signed(in_tdata[pscu_pkg::IN_DATA_W-1:pscu_pkg::RAW_W]);
  assign prod_t1_nxt = $signed({1'b0, pscu_pkg::RECIP_Q48[osr_r[2:0]]}) * raw_t;
  assign prod_p1_nxt = $signed({1'b0, pscu_pkg::RECIP_Q48[osr_r[5:3]]}) * raw_p;

  // stage 2: round to Q24
  logic signed [55:0]   rnd_t2, rnd_p2;
  logic signed [SW-1:0] t2_r, p2_r;

  assign rnd_t2 = prod_t1_r + (prod_t1_r[55] ? 56'sd8388607 : 56'sd8388608);
  assign rnd_p2 = prod_p1_r + (prod_p1_r[55] ? 56'sd8388607 : 56'sd8388608);

  // stage 3: coefficient products
  logic signed [42:0]   tc1_3_r;
  logic signed [46:0]   pc30_3_r, pc21_3_r;
  logic signed [SW-1:0] t3_r, p3_r;

  // stage 4: inner sums and unrounded temperature
  logic signed [43:0]   tq4_r;
  logic signed [47:0]   a4_r, d4_r;
  logic signed [SW-1:0] t4_r, p4_r;

  // stage 5: partial products of a*p, d*p; temperature rounding
  logic signed [55:0]   alo5_r, dlo5_r;
  logic signed [54:0]   ahi5_r, dhi5_r;
  logic                 aneg5_r, dneg5_r;
  logic signed [43:0]   tr5_sum;
  logic signed [27:0]   tr5_r;
  logic signed [SW-1:0] t5_r, p5_r;

  assign tr5_sum = tq4_r + (tq4_r[43] ? 44'sd32767 : 44'sd32768);

  // stage 6: round low partials; clip temperature
  logic signed [55:0]   alo_rnd, dlo_rnd;
  logic signed [31:0]   alr6_r, dlr6_r;
  logic signed [54:0]   ahi6_r, dhi6_r;
  logic signed [pscu_pkg::TEMP_W-1:0] tclip;
  logic                 tsat;
  logic signed [pscu_pkg::TEMP_W-1:0] tout6_r;
  logic                 tsat6_r;
  logic signed [SW-1:0] t6_r, p6_r;

  assign alo_rnd = alo5_r + (aneg5_r ? 56'sd8388607 : 56'sd8388608);
  assign dlo_rnd = dlo5_r + (dneg5_r ? 56'sd8388607 : 56'sd8388608);

  always_comb begin
    tsat  = 1'b0;
    tclip = tr5_r[pscu_pkg::TEMP_W-1:0];
    if (tr5_r > pscu_pkg::TEMP_MAX) begin
      tsat  = 1'b1;
      tclip = pscu_pkg::TEMP_MAX;
    end else if (tr5_r < pscu_pkg::TEMP_MIN) begin
      tsat  = 1'b1;
      tclip = pscu_pkg::TEMP_MIN;
    end
  end

  // stage 7: b and e
  logic signed [55:0]   b_sum7, e_sum7;
  logic signed [51:0]   b7_r, e7_r;
  logic signed [SW-1:0] t7_r, p7_r;

  assign b_sum7 = $signed({c10_r, 24'd0}) + ahi6_r + alr6_r;
  assign e_sum7 = $signed({c01_r, 24'd0}) + dhi6_r + dlr6_r;

  // temperature result delay line, {sat, value}
  logic [pscu_pkg::TEMP_W:0] tdly_r [pscu_pkg::TDLY];

  // stage 8: partial products of b*p, e*t
  logic signed [55:0] blo8_r, elo8_r;
  logic signed [58:0] bhi8_r, ehi8_r;
  logic               bneg8_r, eneg8_r;

  // stage 9: round low partials
  logic signed [55:0] blo_rnd, elo_rnd;
  logic signed [31:0] blr9_r, elr9_r;
  logic signed [58:0] bhi9_r, ehi9_r;

  assign blo_rnd = blo8_r + (bneg8_r ? 56'sd8388607 : 56'sd8388608);
  assign elo_rnd = elo8_r + (eneg8_r ? 56'sd8388607 : 56'sd8388608);

  // stages 10 and 11: pressure in Q24
  logic signed [58:0] bs10_r, es10_r, prs11_r;

  // stage 12: magnitude plus rounding offset
  logic [58:0] prs_u, m12_nxt, m12_r;
  logic        neg12_r;

  assign prs_u   = $unsigned(prs11_r);
  assign m12_nxt = (prs11_r[58] ? ~prs_u : prs_u) + 59'(pscu_pkg::HPA_HALF)
                 + 59'(prs11_r[58]);

  // stage 13: divide by 100 through reciprocal; anything above 2^29 clips anyway
  logic [59:0] q13_r;
  logic        big13_r, neg13_r;

  // final pressure clip into the output buffer
  logic [pscu_pkg::PRS_W-1:0]        q;
  logic signed [pscu_pkg::PRS_W-1:0] pval;
  logic                              psat;

  assign q = q13_r[59:pscu_pkg::DIV100_SHIFT];

  always_comb begin
    psat = 1'b0;
    pval = neg13_r ? $signed(-q) : $signed(q);
    if (big13_r || (!neg13_r && q > pscu_pkg::PRS_POS_LIM) ||
        (neg13_r && q > pscu_pkg::PRS_NEG_LIM)) begin
      psat = 1'b1;
      pval = neg13_r ? pscu_pkg::PRS_MIN : pscu_pkg::PRS_MAX;
    end
  end

  always_comb begin
    res.tmp = $signed(tdly_r[pscu_pkg::TDLY-1][pscu_pkg::TEMP_W-1:0]);
    res.sat = tdly_r[pscu_pkg::TDLY-1][pscu_pkg::TEMP_W] | psat;
    res.prs = pval;
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r           <= '0;
      out_v_r       <= 1'b0;
      sk_v_r        <= 1'b0;
      temp_coeffs_r <= '0;
      c00_r         <= '0;
      c10_r         <= '0;
      c01_r         <= '0;
      c11_r         <= '0;
      c2030_r       <= '0;
      c21_r         <= '0;
      osr_r         <= '0;
    end else begin
      if (en) begin
        v_r <= {v_r[pscu_pkg::STAGES-2:0], in_tvalid};
      end
      if (out_free) begin
        out_v_r <= sk_v_r | arrive;
        sk_v_r  <= 1'b0;
      end else if (arrive) begin
        sk_v_r <= 1'b1;
      end
      if (cfg_wr_en) begin
        case (cfg_index)
          pscu_pkg::REG_TEMP_COEFFS: temp_coeffs_r <= cfg_data[23:0];
          pscu_pkg::REG_C00:         c00_r         <= $signed(cfg_data[19:0]);
          pscu_pkg::REG_C10:         c10_r         <= $signed(cfg_data[19:0]);
          pscu_pkg::REG_C01:         c01_r         <= $signed(cfg_data[15:0]);
          pscu_pkg::REG_C11:         c11_r         <= $signed(cfg_data[15:0]);
          pscu_pkg::REG_C20_C30:     c2030_r       <= cfg_data;
          pscu_pkg::REG_C21:         c21_r         <= $signed(cfg_data[15:0]);
          pscu_pkg::REG_OSR:         osr_r         <= cfg_data[5:0];
          default: ;
        endcase
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (en) begin
      prod_t1_r <= prod_t1_nxt;
      prod_p1_r <= prod_p1_nxt;

      t2_r <= rnd_t2[54:24];
      p2_r <= rnd_p2[54:24];

      tc1_3_r  <= c1 * t2_r;
      pc30_3_r <= c30 * p2_r;
      pc21_3_r <= c21_r * p2_r;
      t3_r     <= t2_r;
      p3_r     <= p2_r;

      tq4_r <= $signed({c0h, 24'd0}) + tc1_3_r;
      a4_r  <= $signed({c20, 24'd0}) + pc30_3_r;
      d4_r  <= $signed({c11_r, 24'd0}) + pc21_3_r;
      t4_r  <= t3_r;
      p4_r  <= p3_r;

      alo5_r  <= $signed({1'b0, a4_r[23:0]}) * p4_r;
      ahi5_r  <= $signed(a4_r[47:24]) * p4_r;
      dlo5_r  <= $signed({1'b0, d4_r[23:0]}) * p4_r;
      dhi5_r  <= $signed(d4_r[47:24]) * p4_r;
      aneg5_r <= a4_r[47] ^ p4_r[SW-1];
      dneg5_r <= d4_r[47] ^ p4_r[SW-1];
      tr5_r   <= tr5_sum[43:16];
      t5_r    <= t4_r;
      p5_r    <= p4_r;

      alr6_r  <= alo_rnd[55:24];
      dlr6_r  <= dlo_rnd[55:24];
      ahi6_r  <= ahi5_r;
      dhi6_r  <= dhi5_r;
      tout6_r <= tclip;
      tsat6_r <= tsat;
      t6_r    <= t5_r;
      p6_r    <= p5_r;

      b7_r <= b_sum7[51:0];
      e7_r <= e_sum7[51:0];
      t7_r <= t6_r;
      p7_r <= p6_r;

      tdly_r[0] <= {tsat6_r, tout6_r};
      for (int i = 1; i < pscu_pkg::TDLY; i++) begin
        tdly_r[i] <= tdly_r[i-1];
      end

      blo8_r  <= $signed({1'b0, b7_r[23:0]}) * p7_r;
      bhi8_r  <= $signed(b7_r[51:24]) * p7_r;
      elo8_r  <= $signed({1'b0, e7_r[23:0]}) * t7_r;
      ehi8_r  <= $signed(e7_r[51:24]) * t7_r;
      bneg8_r <= b7_r[51] ^ p7_r[SW-1];
      eneg8_r <= e7_r[51] ^ t7_r[SW-1];

      blr9_r <= blo_rnd[55:24];
      elr9_r <= elo_rnd[55:24];
      bhi9_r <= bhi8_r;
      ehi9_r <= ehi8_r;

      bs10_r <= $signed({c00_r, 24'd0}) + bhi9_r + blr9_r;
      es10_r <= ehi9_r + elr9_r;

      prs11_r <= bs10_r + es10_r;

      m12_r   <= m12_nxt;
      neg12_r <= prs11_r[58];

      q13_r   <= m12_r[44:16] * pscu_pkg::DIV100_MAGIC;
      big13_r <= |m12_r[58:45];
      neg13_r <= neg12_r;
    end

    if (out_free) begin
      out_r <= sk_v_r ? sk_r : res;
    end else if (arrive) begin
      sk_r <= res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {1'b0, out_r.prs, out_r.tmp};
  assign out_tuser  = out_r.sat;

  // skid entry only ever sits behind a waiting output
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid holds a transfer while output register is empty");

  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_v_r) |-> $past(out_v_r && !out_tready))
    else $error("skid filled without a stalled output");

  a_pipe_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |=> v_r == $past(v_r))
    else $error("pipeline moved while the output buffer was full");

  a_sat_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && out_r.tmp != pscu_pkg::TEMP_MAX && out_r.tmp != pscu_pkg::TEMP_MIN &&
     out_r.prs != pscu_pkg::PRS_MAX && out_r.prs != pscu_pkg::PRS_MIN) |-> !out_r.sat)
    else $error("saturated flag set on an unclipped result");

endmodule

`default_nettype wire

>>> tb/sv/pscu_compensation_checker.sv
`timescale 1ns / 1ps
// pscu_compensation_checker: watches the reading and result streams of the compensation
// unit, predicts every result from its own copy of the coefficient registers and compares
// field by field. Depends on pscu_pkg.
module pscu_compensation_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [pscu_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [pscu_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic [0:0]                      out_tuser,
  input  logic                            cfg_wr_en,
  input  logic [pscu_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pscu_pkg::CFG_DATA_W-1:0] cfg_data,
  output int unsigned                     mismatch_count,
  output int unsigned                     results_outstanding
);

  localparam longint Q24_ONE = 64'sd16777216;
  localparam longint SCALE_FACTOR [8] = '{524288, 1572864, 3670016, 7864320,
                                          253952, 516096, 1040384, 2088960};

  logic [23:0] temp_coeffs_q;
  logic [19:0] c00_q, c10_q;
  logic [15:0] c01_q, c11_q, c21_q;
  logic [31:0] c20_c30_q;
  logic [5:0]  osr_q;

  pscu_pkg::res_t predicted_outputs [$];
  int unsigned    mismatches = 0;
  int unsigned    outstanding = 0;

  assign mismatch_count      = mismatches;
  assign results_outstanding = outstanding;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("ERROR %0t ns: %s got %0d expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  function automatic longint unsigned magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // round(a * b / 2^24), halves away from zero, b taken as a 32-bit magnitude
  function automatic longint mul_round_q24(input longint a, input longint b);
    logic [127:0] prod;
    longint       r;
    prod = 128'(magnitude(a)) * 128'(magnitude(b) & 64'hFFFF_FFFF);
    prod = prod + 128'(1 << 23);
    r = longint'(prod[87:24]);
    return ((a < 0) != (b < 0)) ? -r : r;
  endfunction

  function automatic longint scaled_reading(input logic signed [pscu_pkg::RAW_W-1:0] raw,
                                            input logic [2:0] code);
    longint k, recip;
    k = SCALE_FACTOR[code];
    recip = ((64'sd1 <<< 48) + k / 2) / k;
    return mul_round_q24(recip, raw);
  endfunction

  function automatic longint round_div(input longint v, input longint unsigned d);
    longint unsigned q;
    q = (magnitude(v) + d / 2) / d;
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic pscu_pkg::res_t compensate(input logic [pscu_pkg::IN_DATA_W-1:0] reading);
    logic signed [pscu_pkg::RAW_W-1:0] raw_t, raw_p;
    logic signed [11:0]      c1, c0h;
    logic signed [19:0]      c00, c10;
    logic signed [15:0]      c01, c11, c20, c30, c21;
    longint                  t, p, temp_q24, a, b, d, e, prs_q24, t_out, p_out;
    pscu_pkg::res_t          r;
    raw_t = reading[pscu_pkg::RAW_W-1:0];
    raw_p = reading[2*pscu_pkg::RAW_W-1:pscu_pkg::RAW_W];
    c1  = temp_coeffs_q[23:12];
    c0h = temp_coeffs_q[11:0];
    c00 = c00_q;
    c10 = c10_q;
    c01 = c01_q;
    c11 = c11_q;
    c20 = c20_c30_q[15:0];
    c30 = c20_c30_q[31:16];
    c21 = c21_q;

    t = scaled_reading(raw_t, osr_q[2:0]);
    p = scaled_reading(raw_p, osr_q[5:3]);

    temp_q24 = c0h * Q24_ONE + c1 * t;
    // nested polynomial, each q24 product rounded back to q24
    a = c20 * Q24_ONE + p * c30;
    b = c10 * Q24_ONE + mul_round_q24(a, p);
    d = c11 * Q24_ONE + p * c21;
    e = c01 * Q24_ONE + mul_round_q24(d, p);
    prs_q24 = c00 * Q24_ONE + mul_round_q24(b, p) + mul_round_q24(e, t);

    r.sat = 1'b0;
    t_out = round_div(temp_q24, 65536);
    if (t_out > pscu_pkg::TEMP_MAX) begin
      t_out = pscu_pkg::TEMP_MAX;
      r.sat = 1'b1;
    end else if (t_out < pscu_pkg::TEMP_MIN) begin
      t_out = pscu_pkg::TEMP_MIN;
      r.sat = 1'b1;
    end
    // q24 to hPa in 1/256 units
    p_out = round_div(prs_q24, 6553600);
    if (p_out > pscu_pkg::PRS_MAX) begin
      p_out = pscu_pkg::PRS_MAX;
      r.sat = 1'b1;
    end else if (p_out < pscu_pkg::PRS_MIN) begin
      p_out = pscu_pkg::PRS_MIN;
      r.sat = 1'b1;
    end
    r.tmp = 16'(t_out);
    r.prs = 23'(p_out);
    return r;
  endfunction

  always @(posedge clk) begin : watch
    pscu_pkg::res_t want;
    if (!rst_n) begin
      temp_coeffs_q <= '0;
      c00_q         <= '0;
      c10_q         <= '0;
      c01_q         <= '0;
      c11_q         <= '0;
      c20_c30_q     <= '0;
      c21_q         <= '0;
      osr_q         <= '0;
      predicted_outputs.delete();
      outstanding   <= 0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          pscu_pkg::REG_TEMP_COEFFS: temp_coeffs_q <= cfg_data[23:0];
          pscu_pkg::REG_C00:         c00_q         <= cfg_data[19:0];
          pscu_pkg::REG_C10:         c10_q         <= cfg_data[19:0];
          pscu_pkg::REG_C01:         c01_q         <= cfg_data[15:0];
          pscu_pkg::REG_C11:         c11_q         <= cfg_data[15:0];
          pscu_pkg::REG_C20_C30:     c20_c30_q     <= cfg_data[31:0];
          pscu_pkg::REG_C21:         c21_q         <= cfg_data[15:0];
          pscu_pkg::REG_OSR:         osr_q         <= cfg_data[5:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        predicted_outputs.push_back(compensate(in_tdata));
      if (out_tvalid && out_tready) begin
        if (predicted_outputs.size() == 0) begin
          report_mismatch("result transfer with nothing outstanding, temperature",
                          signed'(out_tdata[15:0]), 0);
        end else begin
          want = predicted_outputs.pop_front();
          if (out_tdata[15:0] !== want.tmp)
            report_mismatch("temperature", signed'(out_tdata[15:0]), want.tmp);
          if (out_tdata[38:16] !== want.prs)
            report_mismatch("pressure", signed'(out_tdata[38:16]), want.prs);
          if (out_tdata[39] !== 1'b0)
            report_mismatch("tdata pad bit", out_tdata[39], 0);
          if (out_tuser[0] !== want.sat)
            report_mismatch("saturated", out_tuser[0], want.sat);
        end
      end
      outstanding <= predicted_outputs.size();
    end
  end

endmodule

>>> tb/sv/pressure_sensor_compensation_unit_tb.sv
`timescale 1ns / 1ps
// pressure_sensor_compensation_unit_tb: drives readings and coefficient sets into the
// compensation unit under random source and sink stalls; pscu_compensation_checker
// predicts and compares the results. Depends on pscu_pkg and the unit itself.
module pressure_sensor_compensation_unit_tb;

  localparam int RAW_W      = pscu_pkg::RAW_W;
  localparam int IN_DATA_W  = pscu_pkg::IN_DATA_W;
  localparam int OUT_DATA_W = pscu_pkg::OUT_DATA_W;
  localparam int CFG_IDX_W  = pscu_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = pscu_pkg::CFG_DATA_W;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 40;
  localparam int ITEMS_PER_PHASE = 115;
  localparam int RANDOM_PHASES   = 6;

  typedef enum {COEF_MAX, COEF_MIN, COEF_TYPICAL, COEF_RANDOM} coef_set_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  out_tready = 1'b0;
  logic                  cfg_wr_en  = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_tready;
  logic                  out_tvalid;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [0:0]            out_tuser;

  int unsigned mismatch_count;
  int unsigned results_outstanding;
  int          sender_idle_pct   = 0;
  int          receiver_idle_pct = 0;
  int          hold_requests     = 0;

  pressure_sensor_compensation_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  pscu_compensation_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_tvalid           (in_tvalid),
    .in_tready           (in_tready),
    .in_tdata            (in_tdata),
    .out_tvalid          (out_tvalid),
    .out_tready          (out_tready),
    .out_tdata           (out_tdata),
    .out_tuser           (out_tuser),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .mismatch_count      (mismatch_count),
    .results_outstanding (results_outstanding)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // result sink: random stalls, plus a long hold-off whenever one is requested
  initial begin : result_sink
    int hold_left;
    int holds_seen;
    hold_left  = 0;
    holds_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left  = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  function automatic int rand_signed(input int span);
    return int'($urandom_range(2 * span)) - span;
  endfunction

  // mostly readings within +-2^21, the rest anywhere in the field
  function automatic logic [RAW_W-1:0] random_raw();
    if ($urandom_range(99) < 60)
      return RAW_W'(rand_signed(1 << 21));
    return RAW_W'($urandom);
  endfunction

  task automatic send_reading(input logic [RAW_W-1:0] raw_t, input logic [RAW_W-1:0] raw_p);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {raw_p, raw_t};
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering and wait until every predicted result has been seen
  task automatic await_drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_outstanding != 0);
  endtask

  task automatic load_coeffs(input coef_set_t set, input logic [5:0] osr);
    logic [CFG_DATA_W-1:0] v [8];
    case (set)
      COEF_MAX: begin
        v[pscu_pkg::REG_TEMP_COEFFS] = {12'h7ff, 12'h7ff};
        v[pscu_pkg::REG_C00]         = 20'h7ffff;
        v[pscu_pkg::REG_C10]         = 20'h7ffff;
        v[pscu_pkg::REG_C01]         = 16'h7fff;
        v[pscu_pkg::REG_C11]         = 16'h7fff;
        v[pscu_pkg::REG_C20_C30]     = 32'h7fff_7fff;
        v[pscu_pkg::REG_C21]         = 16'h7fff;
      end
      COEF_MIN: begin
        v[pscu_pkg::REG_TEMP_COEFFS] = {12'h800, 12'h800};
        v[pscu_pkg::REG_C00]         = 20'h80000;
        v[pscu_pkg::REG_C10]         = 20'h80000;
        v[pscu_pkg::REG_C01]         = 16'h8000;
        v[pscu_pkg::REG_C11]         = 16'h8000;
        v[pscu_pkg::REG_C20_C30]     = 32'h8000_8000;
        v[pscu_pkg::REG_C21]         = 16'h8000;
      end
      COEF_TYPICAL: begin
        v[pscu_pkg::REG_TEMP_COEFFS] = {12'(rand_signed(30)), 12'(rand_signed(60))};
        v[pscu_pkg::REG_C00]         = 20'(rand_signed(200000));
        v[pscu_pkg::REG_C10]         = 20'(rand_signed(60000));
        v[pscu_pkg::REG_C01]         = 16'(rand_signed(3000));
        v[pscu_pkg::REG_C11]         = 16'(rand_signed(2000));
        v[pscu_pkg::REG_C20_C30]     = {16'(rand_signed(1500)), 16'(rand_signed(12000))};
        v[pscu_pkg::REG_C21]         = 16'(rand_signed(200));
      end
      default: begin
        // full-width junk, bits above each register must be dropped
        for (int i = 0; i < 8; i++) v[i] = $urandom;
      end
    endcase
    if (set != COEF_RANDOM) v[pscu_pkg::REG_OSR] = osr;
    for (int i = 0; i < 8; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= CFG_IDX_W'(i);
      cfg_data  <= v[i];
      @(posedge clk);
    end
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // coefficients straight out of reset
    send_reading(24'h000000, 24'h000000);
    send_reading(24'h7fffff, 24'h800000);
    await_drain();

    // largest coefficients with the largest reciprocal: positive clipping
    load_coeffs(COEF_MAX, 6'o44);
    send_reading(24'h000000, 24'h000000);
    send_reading(24'h7fffff, 24'h7fffff);
    send_reading(24'h800000, 24'h800000);
    send_reading(24'h000001, 24'hffffff);
    send_reading(24'hffffff, 24'h000001);
    await_drain();

    // most negative coefficients: negative clipping
    load_coeffs(COEF_MIN, 6'o77);
    send_reading(24'h000000, 24'h000000);
    send_reading(24'h7fffff, 24'h7fffff);
    send_reading(24'h800000, 24'h800000);
    send_reading(24'h7fffff, 24'h800000);
    send_reading(24'h800000, 24'h7fffff);
    await_drain();

    load_coeffs(COEF_TYPICAL, 6'o00);
    send_reading(24'h000000, 24'h000000);
    send_reading(24'h7fffff, 24'h800000);
    send_reading(24'h800000, 24'h7fffff);
    await_drain();

    // every oversampling code on both readings
    for (int code = 0; code < 8; code++) begin
      load_coeffs(COEF_TYPICAL, {3'(code), 3'(7 - code)});
      send_reading(random_raw(), random_raw());
      await_drain();
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      sender_idle_pct   = (phase < 2) ? 36 : (phase < 4) ? 87 : 0;
      receiver_idle_pct = (phase < 2) ? 87 : (phase < 4) ? 36 : 0;
      load_coeffs((phase % 3 == 1) ? COEF_RANDOM : COEF_TYPICAL, 6'($urandom_range(63)));
      // back-pressure the full pipeline while the source keeps offering
      if (phase == RANDOM_PHASES - 1) hold_requests++;
      repeat (ITEMS_PER_PHASE) send_reading(random_raw(), random_raw());
      await_drain();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
